@@ hdl/bsu_pkg.sv @@
// ----------------------------------------------------------------------------
// bsu_pkg
// Shared codes, widths and types of the bounded stack block.
// ----------------------------------------------------------------------------
package bsu_pkg;

    // Fixed field widths
    localparam int KIND_W = 3;
    localparam int CAP_W  = 7;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOP    = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

@@ hdl/bsu_if.sv @@
// ----------------------------------------------------------------------------
// bsu_if
// Valid/ready channels of the bounded stack: operations, results, capacity.
// ----------------------------------------------------------------------------

// Operation channel
interface bsu_in_if #(
    parameter int WIDTH = 32
);
    logic                       valid;
    logic                       ready;
    logic [bsu_pkg::KIND_W-1:0] kind;
    logic [WIDTH-1:0]           push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

// Result channel
interface bsu_out_if #(
    parameter int WIDTH = 32,
    parameter int CNT_W = 7
);
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] entry_count;
    logic [WIDTH-1:0] top_value;
    logic             top_valid;
    logic [WIDTH-1:0] second_value;
    logic             second_valid;
    logic             op_done;

    modport source (output valid, output entry_count, output top_value,
                    output top_valid, output second_value, output second_valid,
                    output op_done, input ready);
    modport sink   (input valid, input entry_count, input top_value,
                    input top_valid, input second_value, input second_valid,
                    input op_done, output ready);
endinterface

// Capacity write channel
interface bsu_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [bsu_pkg::CAP_W-1:0] stack_capacity;

    modport source (output valid, output stack_capacity, input ready);
    modport sink   (input valid, input stack_capacity, output ready);
endinterface

@@ hdl/bsu_ram.sv @@
// ----------------------------------------------------------------------------
// bsu_ram
// Stack store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsu_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/bounded_stack_with_under_top_ops.sv @@
// ----------------------------------------------------------------------------
// bounded_stack_with_under_top_ops
// Bounded LIFO stack with push, pop, remove-second and insert-under-top.
// ----------------------------------------------------------------------------
// Result: registered in the execute state once the result register is free.
// Operations: none is taken until the last one has executed; the store entry
//   third from top is read at every operation transfer.
// Top and second entries live in registers; the store holds the rest.
// Reset: entry count zero, capacity 64, store contents left as they are.
// ----------------------------------------------------------------------------
module bounded_stack_with_under_top_ops #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input logic      clk,
    input logic      rst_n,
    bsu_in_if.sink   item,
    bsu_out_if.source result,
    bsu_cfg_if.sink  cfg
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > bsu_pkg::CAP_W) ? CNT_W : bsu_pkg::CAP_W;

    bsu_pkg::state_t state_reg, state_next;

    logic [bsu_pkg::CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [WIDTH-1:0]           top_reg, top_next;
    logic [WIDTH-1:0]           second_reg, second_next;
    logic [bsu_pkg::KIND_W-1:0] kind_reg;
    logic [WIDTH-1:0]           val_reg;

    logic             out_valid_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic [WIDTH-1:0] out_top_reg;
    logic             out_top_valid_reg;
    logic [WIDTH-1:0] out_second_reg;
    logic             out_second_valid_reg;
    logic             out_done_reg;

    logic             item_xfer;
    logic             out_free;
    logic             exec_fire;
    logic             done;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WIDTH-1:0] wr_data;
    logic [AW-1:0]    rd_addr;
    logic [WIDTH-1:0] rd_data;
    logic [CW-1:0]    n_ext;
    logic [CW-1:0]    cap_ext;
    logic [CW-1:0]    lim;
    logic [CW-1:0]    next_ext;

    // Handshakes
    assign item.ready = (state_reg == bsu_pkg::ST_IDLE);
    assign item_xfer  = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign exec_fire  = (state_reg == bsu_pkg::ST_EXEC) && out_free;
    assign cfg.ready  = 1'b1;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bsu_pkg::CAP_RESET;
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.stack_capacity;
        end
    end

    // Effective limit: capacity clipped to the store depth
    assign cap_ext = CW'(cap_reg);
    assign lim     = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
    assign n_ext   = CW'(count_reg);

    // Store: fetch third from top at transfer, spill on push/insert
    assign rd_addr = AW'(count_reg - CNT_W'(3));

    bsu_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (item_xfer),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Operation decode and next stack state
    always_comb
    begin
        count_next  = count_reg;
        top_next    = top_reg;
        second_next = second_reg;
        done        = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = AW'(count_reg - CNT_W'(2));
        wr_data     = second_reg;
        unique case (kind_reg)
            bsu_pkg::KIND_PUSH:
            begin
                if (n_ext < lim)
                begin
                    wr_en       = exec_fire && (n_ext >= CW'(2));
                    top_next    = val_reg;
                    second_next = top_reg;
                    count_next  = count_reg + CNT_W'(1);
                    done        = 1'b1;
                end
            end
            bsu_pkg::KIND_POP:
            begin
                if (n_ext != '0)
                begin
                    top_next    = second_reg;
                    second_next = rd_data;
                    count_next  = count_reg - CNT_W'(1);
                    done        = 1'b1;
                end
            end
            bsu_pkg::KIND_REMOVE:
            begin
                if (n_ext >= CW'(2))
                begin
                    second_next = rd_data;
                    count_next  = count_reg - CNT_W'(1);
                    done        = 1'b1;
                end
            end
            bsu_pkg::KIND_INSERT:
            begin
                if ((n_ext != '0) && (n_ext <= lim))
                begin
                    if (n_ext < lim)
                    begin
                        wr_en       = exec_fire && (n_ext >= CW'(2));
                        second_next = val_reg;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        top_next = val_reg;
                    end
                    done = 1'b1;
                end
            end
            bsu_pkg::KIND_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign next_ext = CW'(count_next);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bsu_pkg::ST_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = bsu_pkg::ST_EXEC;
                end
            end
            bsu_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = bsu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsu_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsu_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: latched operation, top entries, result register
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            kind_reg <= item.kind;
            val_reg  <= item.push_value;
        end
        if (exec_fire)
        begin
            top_reg              <= top_next;
            second_reg           <= second_next;
            out_count_reg        <= count_next;
            out_top_valid_reg    <= (next_ext >= CW'(1));
            out_top_reg          <= (next_ext >= CW'(1)) ? top_next : '0;
            out_second_valid_reg <= (next_ext >= CW'(2));
            out_second_reg       <= (next_ext >= CW'(2)) ? second_next : '0;
            out_done_reg         <= done;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.entry_count  = out_count_reg;
    assign result.top_value    = out_top_reg;
    assign result.top_valid    = out_top_valid_reg;
    assign result.second_value = out_second_reg;
    assign result.second_valid = out_second_valid_reg;
    assign result.op_done      = out_done_reg;

endmodule
